/* rtl/core/ppfd_pkg.sv */
// ----------------------------------------------------------------------------
// ppfd_pkg
// Shared types and constants for the pulse pair frame decoder.
// ----------------------------------------------------------------------------
package ppfd_pkg;

  localparam int MAX_FRAME_BITS = 256;
  localparam int DURATION_WIDTH = 16;
  localparam int MIN_FRAME_PULSES = 2 + 2;
  localparam int BITS_W = 9;
  localparam int INDEX_W = 8;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_MIN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_MAX   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_MIN    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_MAX    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FOOTER_MIN = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FOOTER_MAX = 3'd5;

  localparam logic [DURATION_WIDTH-1:0] HIGH_MIN_RST   = 16'd450;
  localparam logic [DURATION_WIDTH-1:0] HIGH_MAX_RST   = 16'd800;
  localparam logic [DURATION_WIDTH-1:0] LOW_MIN_RST    = 16'd150;
  localparam logic [DURATION_WIDTH-1:0] LOW_MAX_RST    = 16'd449;
  localparam logic [DURATION_WIDTH-1:0] FOOTER_MIN_RST = 16'd2000;
  localparam logic [DURATION_WIDTH-1:0] FOOTER_MAX_RST = 16'd20000;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_HIGH   = 2'd1,
    CLS_LOW    = 2'd2,
    CLS_FOOTER = 2'd3
  } pulse_class_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ODD       = 3'd1,
    ST_NODATA    = 3'd2,
    ST_BADPAIR   = 3'd3,
    ST_BADFOOTER = 3'd4,
    ST_OVERFLOW  = 3'd5
  } frame_status_t;

  typedef enum logic {
    KIND_BIT    = 1'b0,
    KIND_REPORT = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic [DURATION_WIDTH-1:0] pulse_duration;
    logic                      capture_end;
  } in_item_t;

  typedef struct packed {
    item_kind_t         item_kind;
    logic               bit_value;
    logic [INDEX_W-1:0] bit_index;
    frame_status_t      frame_status;
    logic [BITS_W-1:0]  frame_bits;
  } out_item_t;

  typedef struct packed {
    logic [DURATION_WIDTH-1:0] high_min;
    logic [DURATION_WIDTH-1:0] high_max;
    logic [DURATION_WIDTH-1:0] low_min;
    logic [DURATION_WIDTH-1:0] low_max;
    logic [DURATION_WIDTH-1:0] footer_min;
    logic [DURATION_WIDTH-1:0] footer_max;
  } windows_t;

endpackage

/* rtl/core/pulse_pair_frame_decoder.sv */
// ----------------------------------------------------------------------------
// pulse_pair_frame_decoder
// Decodes captured RF pulse durations into data bits and frame reports.
//
// Input channel (in_valid/in_stall/in_data): one pulse duration per item,
// capture_end set on the last pulse of a frame. Output channel
// (out_valid/out_stall/out_data): a data bit item for each good high-low or
// low-high pair in an error-free frame under its bit limit, and one report
// item with status and bit count on the last pulse. Other pulses give none.
// Path: an accepted item is registered in the input register, classified and
// decoded from it, and its result is registered in the output register, from
// which out_valid shows it until it is taken.
// Throughput: one item per cycle while out_stall is low; the input and output
// registers let a new item enter while a result waits to be taken.
// Stall: while out_stall holds a result, the item in the input register
// waits and in_stall rises; nothing is dropped.
// Reset: windows return to their defaults and frame state clears.
// Config: cfg_we/cfg_index/cfg_data write a window; writing only while the block is idle is up to the user.
// ----------------------------------------------------------------------------
module pulse_pair_frame_decoder import ppfd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [DURATION_WIDTH-1:0] cfg_data
);

  windows_t     windows;
  logic         hold_valid;
  in_item_t     hold;
  logic         out_free;
  logic         advance;
  pulse_class_t pulse_class;
  logic         res_valid;
  out_item_t    res;

  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      windows.high_min   <= HIGH_MIN_RST;
      windows.high_max   <= HIGH_MAX_RST;
      windows.low_min    <= LOW_MIN_RST;
      windows.low_max    <= LOW_MAX_RST;
      windows.footer_min <= FOOTER_MIN_RST;
      windows.footer_max <= FOOTER_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_MIN:   windows.high_min   <= cfg_data;
        REG_HIGH_MAX:   windows.high_max   <= cfg_data;
        REG_LOW_MIN:    windows.low_min    <= cfg_data;
        REG_LOW_MAX:    windows.low_max    <= cfg_data;
        REG_FOOTER_MIN: windows.footer_min <= cfg_data;
        REG_FOOTER_MAX: windows.footer_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold <= in_data;
    end
  end

  ppfd_classify u_classify (
    .duration    (hold.pulse_duration),
    .windows     (windows),
    .pulse_class (pulse_class)
  );

  ppfd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .capture_end (hold.capture_end),
    .pulse_class (pulse_class),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && res_valid) begin
      out_data <= res;
    end
  end

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    hold_valid && out_valid && out_stall |-> in_stall)
    else $error("input taken while both registers are blocked");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  a_hold_holds: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> hold_valid && $stable(hold))
    else $error("waiting input item changed");

endmodule

/* rtl/core/ppfd_classify.sv */
// ----------------------------------------------------------------------------
// ppfd_classify
// Sorts one pulse duration into high, low, footer or none; first window wins.
// ----------------------------------------------------------------------------
module ppfd_classify import ppfd_pkg::*; (
  input  logic [DURATION_WIDTH-1:0] duration,
  input  windows_t                  windows,
  output pulse_class_t              pulse_class
);

  logic in_high;
  logic in_low;
  logic in_footer;

  assign in_high   = (duration >= windows.high_min) && (duration <= windows.high_max);
  assign in_low    = (duration >= windows.low_min) && (duration <= windows.low_max);
  assign in_footer = (duration >= windows.footer_min) && (duration <= windows.footer_max);

  always_comb begin
    if (in_high) begin
      pulse_class = CLS_HIGH;
    end else if (in_low) begin
      pulse_class = CLS_LOW;
    end else if (in_footer) begin
      pulse_class = CLS_FOOTER;
    end else begin
      pulse_class = CLS_NONE;
    end
  end

endmodule

/* rtl/core/ppfd_frame.sv */
// ----------------------------------------------------------------------------
// ppfd_frame
// Frame state: pairs pulses into bits, tracks errors, builds the result item.
// ----------------------------------------------------------------------------
module ppfd_frame import ppfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         capture_end,
  input  pulse_class_t pulse_class,
  output logic         res_valid,
  output out_item_t    res
);

  logic              second_of_pair;
  pulse_class_t      first_pulse_class;
  logic [BITS_W-1:0] bits_so_far;
  frame_status_t     pending_error;

  logic              second_of_pair_next;
  pulse_class_t      first_pulse_class_next;
  logic [BITS_W-1:0] bits_so_far_next;
  frame_status_t     pending_error_next;

  logic is_one;
  logic is_zero;
  logic at_limit;

  assign is_one   = (first_pulse_class == CLS_HIGH) && (pulse_class == CLS_LOW);
  assign is_zero  = (first_pulse_class == CLS_LOW) && (pulse_class == CLS_HIGH);
  assign at_limit = bits_so_far >= BITS_W'(MAX_FRAME_BITS);

  always_comb begin
    second_of_pair_next    = second_of_pair;
    first_pulse_class_next = first_pulse_class;
    bits_so_far_next       = bits_so_far;
    pending_error_next     = pending_error;
    res_valid              = 1'b0;
    res.item_kind          = KIND_BIT;
    res.bit_value          = 1'b0;
    res.bit_index          = '0;
    res.frame_status       = ST_OK;
    res.frame_bits         = '0;
    if (capture_end) begin
      res_valid      = 1'b1;
      res.item_kind  = KIND_REPORT;
      res.frame_bits = bits_so_far;
      if (!second_of_pair) begin
        res.frame_status =
          (bits_so_far < BITS_W'(MIN_FRAME_PULSES / 2)) ? ST_NODATA : ST_ODD;
      end else if (bits_so_far == '0) begin
        res.frame_status = ST_NODATA;
      end else if (!((first_pulse_class == CLS_HIGH) && (pulse_class == CLS_FOOTER))) begin
        res.frame_status = ST_BADFOOTER;
      end else begin
        res.frame_status = pending_error;
      end
      second_of_pair_next    = 1'b0;
      first_pulse_class_next = CLS_NONE;
      bits_so_far_next       = '0;
      pending_error_next     = ST_OK;
    end else if (!second_of_pair) begin
      first_pulse_class_next = pulse_class;
      second_of_pair_next    = 1'b1;
    end else begin
      second_of_pair_next    = 1'b0;
      first_pulse_class_next = CLS_NONE;
      if (!(is_one || is_zero)) begin
        if (pending_error == ST_OK) begin
          pending_error_next = ST_BADPAIR;
        end
      end else if (at_limit) begin
        if (pending_error == ST_OK) begin
          pending_error_next = ST_OVERFLOW;
        end
      end else if (pending_error == ST_OK) begin
        res_valid     = 1'b1;
        res.bit_value = is_one;
        res.bit_index = bits_so_far[INDEX_W-1:0];
      end
      if (!at_limit) begin
        bits_so_far_next = bits_so_far + BITS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_of_pair    <= 1'b0;
      first_pulse_class <= CLS_NONE;
      bits_so_far       <= '0;
      pending_error     <= ST_OK;
    end else if (advance) begin
      second_of_pair    <= second_of_pair_next;
      first_pulse_class <= first_pulse_class_next;
      bits_so_far       <= bits_so_far_next;
      pending_error     <= pending_error_next;
    end
  end

  a_bits_bounded: assert property (@(posedge clk) disable iff (rst)
    bits_so_far <= BITS_W'(MAX_FRAME_BITS))
    else $error("bit count past frame limit");

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    advance && capture_end |=> !second_of_pair && bits_so_far == '0
      && pending_error == ST_OK)
    else $error("frame state not cleared after report");

  a_bit_needs_clean_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.item_kind == KIND_BIT |-> pending_error == ST_OK && second_of_pair)
    else $error("bit emitted outside a clean pair");

endmodule
